[hdl/spd_pkg.sv]
`default_nettype none
package spd_pkg;

	// Captured bytes per packet: id, length and fifteen bytes of sensor data.
	localparam int CAPTURE_BYTES = 17;
	localparam int CAP_IDX_W = $clog2(CAPTURE_BYTES);
	localparam int DATA_W = (CAPTURE_BYTES - 2) * 8;
	localparam logic [8:0] EXTRA_BYTES = 9'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_PACKETS = 3'd4;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_WARMUP = 2'd1,
		ST_REJECT = 2'd2
	} spd_status_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] expected_id;
		logic [7:0] expected_length;
		logic [7:0] warmup_packets;
	} spd_cfg_t;

	typedef logic [CAPTURE_BYTES-1:0][7:0] spd_capture_t;

endpackage
`default_nettype wire

[hdl/sensor_packet_deframer_top.sv]
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: rx_byte
// m_        out        m_tvalid / m_tready    m_tdata: sensor fields, m_tuser: status
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One received byte is taken per cycle while the packet queue has room. A packet result
// passes through the packet queue into the output register, once that register is free.
// The parser stalls only while the packet queue (QUEUE_DEPTH entries) is full.
// The output register holds a result until it is taken, while parsing carries on.
// Reset returns the parser to the header hunt and restores register defaults.
`default_nettype none
module sensor_packet_deframer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [15:0] sense_time, [23:16] bumper, [31:24] drop_flags, [39:32] cliff,
	// [55:40] left_count, [71:56] right_count, [87:72] motor_pwm,
	// [95:88] buttons, [103:96] charger, [111:104] battery, [119:112] overload
	output logic [spd_pkg::DATA_W-1:0]         m_tdata,
	output logic [1:0]                         m_tuser,   // [1:0] status
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);

	spd_pkg::spd_cfg_t     cfg_q;
	logic                  q_push_valid;
	logic                  q_push_ready;
	spd_pkg::spd_capture_t q_push_data;
	logic                  q_pop_valid;
	logic                  q_pop_ready;
	spd_pkg::spd_capture_t q_pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first <= 8'd170;
			cfg_q.header_second <= 8'd85;
			cfg_q.expected_id <= 8'd1;
			cfg_q.expected_length <= 8'd15;
			cfg_q.warmup_packets <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spd_pkg::REG_HEADER_FIRST:    cfg_q.header_first <= cfg_data;
				spd_pkg::REG_HEADER_SECOND:   cfg_q.header_second <= cfg_data;
				spd_pkg::REG_EXPECTED_ID:     cfg_q.expected_id <= cfg_data;
				spd_pkg::REG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_data;
				spd_pkg::REG_WARMUP_PACKETS:  cfg_q.warmup_packets <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	spd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	spd_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(spd_pkg::spd_capture_t))
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	spd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTHESIS
	a_no_lost_packet: assert property (@(posedge clk) disable iff (!arst_n)
		q_push_valid |-> q_push_ready)
		else $error("closed packet offered to a full queue");

	a_queued_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push_valid && q_push_ready && !(q_pop_valid && q_pop_ready)) |=> q_pop_valid)
		else $error("queued packet not visible to the back end");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == spd_pkg::ST_REJECT)) |-> (m_tdata == '0))
		else $error("rejected packet carries sensor data");
`endif

endmodule
`default_nettype wire

[hdl/spd_front.sv]
`default_nettype none
module spd_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire spd_pkg::spd_cfg_t     cfg,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output spd_pkg::spd_capture_t      push_data
);

	typedef enum logic [3:0] {
		PH_HDR1 = 4'b0001,
		PH_HDR2 = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_BODY = 4'b1000
	} spd_phase_t;

	spd_phase_t            phase_q;
	logic [7:0]            payload_len_q;
	logic [8:0]            byte_count_q;
	spd_pkg::spd_capture_t capture_q;

	logic in_fire;
	logic body_more;

	// Bytes are taken whenever a finished packet could still be queued.
	assign s_tready = push_ready;
	assign in_fire = s_tvalid && s_tready;
	assign body_more = byte_count_q < ({1'b0, payload_len_q} + spd_pkg::EXTRA_BYTES);
	assign push_valid = in_fire && (phase_q == PH_BODY) && !body_more;
	assign push_data = capture_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			payload_len_q <= '0;
			byte_count_q <= '0;
			capture_q <= '0;
		end else if (in_fire) begin
			case (phase_q)
				PH_HDR1: begin
					if (s_tdata == cfg.header_first)
						phase_q <= PH_HDR2;
				end
				PH_HDR2: begin
					phase_q <= (s_tdata == cfg.header_second) ? PH_LEN : PH_HDR1;
				end
				PH_LEN: begin
					payload_len_q <= s_tdata;
					phase_q <= PH_BODY;
				end
				PH_BODY: begin
					if (body_more) begin
						for (int i = 0; i < spd_pkg::CAPTURE_BYTES; i++) begin
							if (byte_count_q == 9'(i))
								capture_q[i] <= s_tdata;
						end
						byte_count_q <= byte_count_q + 9'd1;
					end else begin
						// The closing byte itself is dropped; the store starts afresh.
						capture_q <= '0;
						byte_count_q <= '0;
						payload_len_q <= '0;
						phase_q <= PH_HDR1;
					end
				end
				default: begin
					phase_q <= PH_HDR1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/spd_queue.sv]
`default_nettype none
module spd_queue #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

[hdl/spd_back.sv]
`default_nettype none
module spd_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire spd_pkg::spd_cfg_t          cfg,
	input  wire logic                       pop_valid,
	output logic                            pop_ready,
	input  wire spd_pkg::spd_capture_t      pop_data,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [spd_pkg::DATA_W-1:0]      m_tdata,
	output logic [1:0]                      m_tuser
);

	logic                       m_tvalid_q;
	logic [spd_pkg::DATA_W-1:0] m_tdata_q;
	spd_pkg::spd_status_t       status_q;
	logic [7:0]                 warmup_count_q;

	logic ok;
	logic warm;
	logic take;

	assign pop_ready = !m_tvalid_q || m_tready;
	assign take = pop_valid && pop_ready;
	assign ok = (pop_data[0] == cfg.expected_id) && (pop_data[1] == cfg.expected_length);
	assign warm = warmup_count_q < cfg.warmup_packets;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			warmup_count_q <= '0;
		end else begin
			if (take)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			// Every closed packet counts towards warm-up, rejected ones too.
			if (take && warm)
				warmup_count_q <= warmup_count_q + 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (ok) begin
				status_q <= warm ? spd_pkg::ST_WARMUP : spd_pkg::ST_ACCEPT;
				// Captured bytes two onwards are already in the output field order.
				m_tdata_q <= pop_data[spd_pkg::CAPTURE_BYTES-1:2];
			end else begin
				status_q <= spd_pkg::ST_REJECT;
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = status_q;

endmodule
`default_nettype wire

[tb/sv/sensor_frame_checker.sv]
module sensor_frame_checker
	import spd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [DATA_W-1:0]     m_tdata,
	input  wire logic [1:0]            m_tuser,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]            cfg_data,
	output int                         outstanding,
	output int                         delivered,
	output int                         mismatches
);

	typedef enum logic [3:0] {
		SEEK_FIRST    = 4'b0001,
		SEEK_SECOND   = 4'b0010,
		TAKE_LENGTH   = 4'b0100,
		COLLECT_BYTES = 4'b1000
	} hunt_phase_t;

	// Laid out so that a cast from m_tdata lands each field on its own bits.
	typedef struct packed {
		logic [7:0]  overload;
		logic [7:0]  battery;
		logic [7:0]  charger;
		logic [7:0]  buttons;
		logic [15:0] motor_pwm;
		logic [15:0] right_count;
		logic [15:0] left_count;
		logic [7:0]  cliff;
		logic [7:0]  drop_flags;
		logic [7:0]  bumper;
		logic [15:0] sense_time;
	} sensor_fields_t;

	typedef struct {
		spd_status_t    status;
		sensor_fields_t data;
	} sensor_frame_t;

	spd_cfg_t       regs;
	hunt_phase_t    phase;
	logic [7:0]     frame_len;
	logic [8:0]     collected;
	spd_capture_t   capture;
	logic [7:0]     warm_count;
	sensor_frame_t  awaited_frames[$];

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_frame();
		sensor_frame_t  want;
		sensor_fields_t got;
		got = m_tdata;
		if (awaited_frames.size() == 0) begin
			$error("status: expected no result, got %0d", m_tuser);
			mismatches++;
		end else begin
			want = awaited_frames.pop_front();
			compare_field("status", 16'(want.status), 16'(m_tuser));
			compare_field("sense_time", want.data.sense_time, got.sense_time);
			compare_field("bumper", 16'(want.data.bumper), 16'(got.bumper));
			compare_field("drop_flags", 16'(want.data.drop_flags), 16'(got.drop_flags));
			compare_field("cliff", 16'(want.data.cliff), 16'(got.cliff));
			compare_field("left_count", want.data.left_count, got.left_count);
			compare_field("right_count", want.data.right_count, got.right_count);
			compare_field("motor_pwm", want.data.motor_pwm, got.motor_pwm);
			compare_field("buttons", 16'(want.data.buttons), 16'(got.buttons));
			compare_field("charger", 16'(want.data.charger), 16'(got.charger));
			compare_field("battery", 16'(want.data.battery), 16'(got.battery));
			compare_field("overload", 16'(want.data.overload), 16'(got.overload));
		end
		delivered <= delivered + 1;
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		case (idx)
			REG_HEADER_FIRST: regs.header_first = value;
			REG_HEADER_SECOND: regs.header_second = value;
			REG_EXPECTED_ID: regs.expected_id = value;
			REG_EXPECTED_LENGTH: regs.expected_length = value;
			REG_WARMUP_PACKETS: regs.warmup_packets = value;
			default: ;
		endcase
	endtask

	task automatic parse_rx_byte(input logic [7:0] rx);
		sensor_frame_t frame;
		case (phase)
			SEEK_FIRST: begin
				if (rx == regs.header_first)
					phase = SEEK_SECOND;
			end
			// A wrong second byte drops the hunt without looking at it as a first byte.
			SEEK_SECOND: phase = (rx == regs.header_second) ? TAKE_LENGTH : SEEK_FIRST;
			TAKE_LENGTH: begin
				frame_len = rx;
				phase = COLLECT_BYTES;
			end
			default: begin
				if (int'(collected) < int'(frame_len) + int'(EXTRA_BYTES)) begin
					if (int'(collected) < CAPTURE_BYTES)
						capture[CAP_IDX_W'(collected)] = rx;
					collected = collected + 9'd1;
				end else begin
					// The closing byte itself is swallowed.
					frame.status = ST_REJECT;
					frame.data = '0;
					if (capture[0] == regs.expected_id && capture[1] == regs.expected_length) begin
						frame.status = (warm_count < regs.warmup_packets) ? ST_WARMUP : ST_ACCEPT;
						frame.data.sense_time = {capture[3], capture[2]};
						frame.data.bumper = capture[4];
						frame.data.drop_flags = capture[5];
						frame.data.cliff = capture[6];
						frame.data.left_count = {capture[8], capture[7]};
						frame.data.right_count = {capture[10], capture[9]};
						frame.data.motor_pwm = {capture[12], capture[11]};
						frame.data.buttons = capture[13];
						frame.data.charger = capture[14];
						frame.data.battery = capture[15];
						frame.data.overload = capture[16];
					end
					awaited_frames.push_back(frame);
					collected = '0;
					frame_len = '0;
					capture = '0;
					phase = SEEK_FIRST;
					if (warm_count < regs.warmup_packets)
						warm_count = warm_count + 8'd1;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.header_first = 8'd170;
			regs.header_second = 8'd85;
			regs.expected_id = 8'd1;
			regs.expected_length = 8'd15;
			regs.warmup_packets = 8'd5;
			phase = SEEK_FIRST;
			frame_len = '0;
			collected = '0;
			capture = '0;
			warm_count = '0;
			awaited_frames.delete();
			mismatches = 0;
			outstanding <= 0;
			delivered <= 0;
		end else begin
			// A result leaving now can never stem from a byte taken at the same edge.
			if (m_tvalid && m_tready)
				check_frame();
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			outstanding <= awaited_frames.size();
		end
	end

endmodule

[tb/sv/tb_sensor_packet_deframer_top.sv]
module tb_sensor_packet_deframer_top;
	import spd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [7:0]            cfg_data;

	int pending_frames;
	int frames_checked;
	int fault_count;
	int items_sent = 0;
	int cycle_count = 0;
	bit calm = 1'b0;

	// Mirror of the header and check registers, used to build well-formed packets.
	logic [7:0] sync_first = 8'd170;
	logic [7:0] sync_second = 8'd85;
	logic [7:0] want_id = 8'd1;
	logic [7:0] want_len = 8'd15;

	sensor_packet_deframer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sensor_frame_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(pending_frames),
		.delivered(frames_checked),
		.mismatches(fault_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Each call returns at the edge where its transaction completed, with tvalid still high.
	task automatic push_byte(input logic [7:0] rx);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Waits until every packet result has been taken, then lets the pipeline empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_frames != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] id, input logic [7:0] len, input logic [7:0] warm);
		logic [CFG_IDX_W-1:0] spare;
		spare = CFG_IDX_W'(int'(REG_WARMUP_PACKETS) + 1 + int'($urandom_range(0, 2)));
		settle();
		write_reg(REG_HEADER_FIRST, first);
		write_reg(REG_HEADER_SECOND, second);
		write_reg(spare, 8'($urandom));
		write_reg(REG_EXPECTED_ID, id);
		write_reg(REG_EXPECTED_LENGTH, len);
		write_reg(REG_WARMUP_PACKETS, warm);
		cfg_valid <= 1'b0;
		sync_first = first;
		sync_second = second;
		want_id = id;
		want_len = len;
	endtask

	task automatic send_packet();
		int         pick;
		int         i;
		logic [7:0] plen;
		logic [7:0] rx;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			plen = 8'd15;
		else if (pick < 85)
			plen = 8'($urandom_range(0, 20));
		else if (pick < 97)
			plen = 8'($urandom_range(21, 40));
		else
			plen = 8'd255;
		push_byte(sync_first);
		push_byte(sync_second);
		push_byte(plen);
		for (i = 0; i < int'(plen) + 2; i++) begin
			rx = 8'($urandom);
			if (i == 0 && $urandom_range(0, 9) != 0)
				rx = want_id;
			else if (i == 1 && $urandom_range(0, 9) != 0)
				rx = want_len;
			push_byte(rx);
		end
		push_byte(8'($urandom));
	endtask

	task automatic random_phase(input int n_items, input int n_frames);
		int start_items;
		int start_frames;
		int pick;
		int n;
		start_items = items_sent;
		start_frames = frames_checked;
		while (items_sent - start_items < n_items || frames_checked - start_frames < n_frames) begin
			calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				send_packet();
			end else if (pick < 84) begin
				n = $urandom_range(1, 4);
				repeat (n) push_byte(8'($urandom));
			end else if (pick < 94) begin
				push_byte(sync_first);
				push_byte(8'($urandom));
			end else begin
				// A packet cut short: the bytes that follow are taken as its payload.
				push_byte(sync_first);
				push_byte(sync_second);
				push_byte(8'($urandom_range(0, 20)));
				n = $urandom_range(0, 6);
				repeat (n) push_byte(8'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [7:0] opening [22];
		opening = '{
			// Second header byte wrong, then a byte that is not the first header.
			8'hAA, 8'hAA, 8'h55,
			// Zero length, good id and length bytes: a warm-up result with empty fields.
			8'hAA, 8'h55, 8'h00, 8'h01, 8'h0F, 8'h00,
			// Zero length with both check bytes wrong.
			8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF,
			// Good id but wrong length byte.
			8'hAA, 8'h55, 8'h01, 8'h01, 8'h00, 8'hFF, 8'h7E
		};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			push_byte(opening[i]);
		random_phase(300, 10);

		program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
		random_phase(200, 10);

		program_regs(8'($urandom), 8'($urandom), 8'h00, 8'hFF, 8'hFF);
		random_phase(200, 10);

		// The warm-up count is well past this limit by now, so it must hold still.
		program_regs(8'hFF, 8'h00, 8'($urandom), 8'd15, 8'd3);
		random_phase(200, 10);

		program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		random_phase(200, 10);

		settle();
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
